// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the tokenizer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clk edge outside reset
`define QCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define QCT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/qct_pkg.sv
// ---------------------------------------------------------------------------
// qct_pkg
// types and codes shared by the quoted command tokenizer
// ---------------------------------------------------------------------------
package qct_pkg;

  // tokenizer modes
  localparam logic [2:0] MODE_BETWEEN = 3'd0;
  localparam logic [2:0] MODE_TOKEN   = 3'd1;
  localparam logic [2:0] MODE_ESC     = 3'd2;
  localparam logic [2:0] MODE_DQ      = 3'd3;
  localparam logic [2:0] MODE_DQ_ESC  = 3'd4;
  localparam logic [2:0] MODE_SQ      = 3'd5;
  localparam logic [2:0] MODE_DISCARD = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TEND = 2'd1;
  localparam logic [1:0] KIND_OK   = 2'd2;
  localparam logic [1:0] KIND_INC  = 2'd3;

  // special characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } res_t;

  // results caused by one input item
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } step_res_t;

endpackage

// File: rtl/quoted_command_tokenizer_top.sv
// ---------------------------------------------------------------------------
// quoted_command_tokenizer_top
// byte-wise shell style command tokenizer with quotes and escapes
// ---------------------------------------------------------------------------
// usage
//   in channel : one item per character byte (in_tuser = 0, in_tdata = byte)
//                or an end of expression mark (in_tuser = 1, in_tdata ignored)
//   out channel: token bytes, token end marks and command end marks; the
//                kind travels in out_tuser, the byte in out_tdata, and
//                out_tlast flags the final result of one input item
// throughput
//   an item's results enter the result queue when the item is accepted
//   one item accepted per cycle while the queue has room; an item yields zero,
//   one or two results and the out channel carries one result per cycle, so a
//   run of items with two results each is limited by the out side
//   the single mode register is updated on each accepted item
// reset
//   synchronous active-low rst_n returns the mode to between tokens and
//   empties the result queue
// stall
//   a four-entry result queue parts the two sides; in_tready stays high
//   while at least two entries are free, so a stalled receiver backs the
//   input up as soon as fewer than two entries are free, which can be before the queue fills
// ---------------------------------------------------------------------------
module quoted_command_tokenizer_top import qct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input item channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tuser,   // [0] action
  // result item channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] ch_res
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast   // last result of an input item
);

  logic      in_accept;
  step_res_t step_res;
  res_t      head;
  logic      q_room;

  assign in_tready = q_room;
  assign in_accept = in_tvalid && in_tready;

  // mode tracking and decode of the incoming byte
  qct_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .action (in_tuser),
    .ch     (in_tdata),
    .res    (step_res)
  );

  // result queue towards the out channel
  qct_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_res  (step_res),
    .room      (q_room),
    .out_valid (out_tvalid),
    .out_res   (head),
    .out_ready (out_tready)
  );

  assign out_tdata = head.ch;
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// File: rtl/qct_step.sv
// ---------------------------------------------------------------------------
// qct_step
// mode register and per-byte decode into up to two results
// ---------------------------------------------------------------------------
module qct_step import qct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       action,
  input  logic [7:0] ch,
  output step_res_t  res
);

  logic [2:0] mode_r;
  logic [2:0] mode_nxt;
  logic [2:0] m;
  logic       is_sep;
  logic       is_eol;

  always_comb begin
    m      = (mode_r > MODE_DISCARD) ? MODE_BETWEEN : mode_r;
    is_sep = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
    is_eol = (ch == CH_CR) || (ch == CH_LF) || (ch == CH_SEMI);
    mode_nxt = m;
    res      = '0;

    if ((action && m != MODE_DISCARD) || (!action && m != MODE_DISCARD &&
        (ch == CH_NUL || is_eol))) begin
      // command end, with a token end first when a token is open
      mode_nxt = (!action && ch == CH_NUL) ? MODE_DISCARD : MODE_BETWEEN;
      if (m != MODE_BETWEEN) begin
        res.num     = 2'd2;
        res.r0.kind = KIND_TEND;
        res.r1.kind = (m == MODE_TOKEN) ? KIND_OK : KIND_INC;
        res.r1.last = 1'b1;
      end else begin
        res.num     = 2'd1;
        res.r0.kind = KIND_OK;
        res.r0.last = 1'b1;
      end
    end else if (action) begin
      mode_nxt = MODE_BETWEEN;
    end else begin
      case (m)
        MODE_BETWEEN, MODE_TOKEN: begin
          if (is_sep) begin
            if (m == MODE_TOKEN) begin
              res.num     = 2'd1;
              res.r0.kind = KIND_TEND;
              res.r0.last = 1'b1;
            end
            mode_nxt = MODE_BETWEEN;
          end else if (ch == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else if (ch == CH_DQUOTE) begin
            mode_nxt = MODE_DQ;
          end else if (ch == CH_SQUOTE) begin
            mode_nxt = MODE_SQ;
          end else begin
            res.num     = 2'd1;
            res.r0.kind = KIND_BYTE;
            res.r0.ch   = ch;
            res.r0.last = 1'b1;
            mode_nxt    = MODE_TOKEN;
          end
        end
        MODE_ESC: begin
          res.num     = 2'd1;
          res.r0.kind = KIND_BYTE;
          res.r0.ch   = ch;
          res.r0.last = 1'b1;
          mode_nxt    = MODE_TOKEN;
        end
        MODE_DQ: begin
          if (ch == CH_DQUOTE) begin
            mode_nxt = MODE_TOKEN;
          end else if (ch == CH_BSLASH) begin
            mode_nxt = MODE_DQ_ESC;
          end else begin
            res.num     = 2'd1;
            res.r0.kind = KIND_BYTE;
            res.r0.ch   = ch;
            res.r0.last = 1'b1;
          end
        end
        MODE_DQ_ESC: begin
          res.num     = 2'd1;
          res.r0.kind = KIND_BYTE;
          res.r0.ch   = ch;
          res.r0.last = 1'b1;
          mode_nxt    = MODE_DQ;
        end
        MODE_SQ: begin
          if (ch == CH_SQUOTE) begin
            mode_nxt = MODE_TOKEN;
          end else begin
            res.num     = 2'd1;
            res.r0.kind = KIND_BYTE;
            res.r0.ch   = ch;
            res.r0.last = 1'b1;
          end
        end
        default: begin
          // discarding until end of expression
          mode_nxt = MODE_DISCARD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BETWEEN;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// File: rtl/qct_outq.sv
// ---------------------------------------------------------------------------
// qct_outq
// small result queue, up to two pushes and one pop per cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qct_outq import qct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  step_res_t  push_res,
  output logic       room,
  output logic       out_valid,
  output res_t       out_res,
  input  logic       out_ready
);

  res_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_r;
  logic [QAW-1:0] rd_r;
  logic [QAW:0]   cnt_r;
  logic [QAW:0]   cnt_nxt;
  logic [1:0]     n_push;
  logic           pop;

  assign room      = (cnt_r <= (QAW+1)'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? push_res.num : 2'd0;
  assign cnt_nxt   = cnt_r + (QAW+1)'(n_push) - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_r] <= push_res.r0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_r + QAW'(1)] <= push_res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QAW'(n_push);
      rd_r  <= rd_r + QAW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  `QCT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= (QAW+1)'(QDEPTH), "result queue overflow")
  `QCT_ASSERT_IMP(a_push_room, push && push_res.num != 2'd0, room, "push without room")
  `QCT_ASSERT_NXT(a_pop_only, pop && n_push == 2'd0, cnt_r == $past(cnt_r) - 1'b1,
    "pop did not drop count")
  `QCT_ASSERT_IMP(a_ptr_gap, 1'b1, QAW'(wr_r - rd_r) == cnt_r[QAW-1:0], "pointer gap mismatch")

endmodule
